@@ rtl/core/ftrc_pkg.sv @@
`timescale 1ns / 1ps

package ftrc_pkg;

    // Number of CORDIC vectoring stages (8 to 24).
    localparam int CORDIC_STAGES = 16;
    // CORDIC datapath widths: 57-bit scaled differences plus gain headroom.
    localparam int CORDIC_W = 60;
    localparam int ANG_W    = 32;

    // Restoring divider: quotient bits, divisor width, sideband width.
    localparam int DIV_STEPS = 23;
    localparam int DIV_DW    = 16;
    localparam int DIV_TAG_W = 28;

    // Queue between the classifying front and the executing back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // Register indexes.
    localparam logic [2:0] CFG_TARGET_RADIUS = 3'd0;
    localparam logic [2:0] CFG_SLOW_RADIUS   = 3'd1;
    localparam logic [2:0] CFG_TIME_TO_TGT   = 3'd2;
    localparam logic [2:0] CFG_MAX_SPEED     = 3'd3;
    localparam logic [2:0] CFG_MAX_ACCEL     = 3'd4;

    // Register reset values.
    localparam logic [13:0] TARGET_RADIUS_RST = 14'd410;
    localparam logic [13:0] SLOW_RADIUS_RST   = 14'd2048;
    localparam logic [15:0] TIME_TO_TGT_RST   = 16'd410;
    localparam logic [22:0] MAX_SPEED_RST     = 23'd8192;
    localparam logic [22:0] MAX_ACCEL_RST     = 23'd16384;

    // Result status codes.
    localparam logic [1:0] STATUS_STEER     = 2'd0;
    localparam logic [1:0] STATUS_COINCIDE  = 2'd1;
    localparam logic [1:0] STATUS_IN_RADIUS = 2'd2;

    // Angle constants in Q3.12 and Q28.
    localparam logic signed [17:0] ANG_PI      = 18'sd12868;
    localparam logic [17:0]        ANG_2PI     = 18'd25736;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q28 = 32'sd421657428;
    localparam logic signed [ANG_W-1:0] ROUND_Q16   = 32'sd32768;

    typedef struct packed {
        logic signed [31:0] owner_x;
        logic signed [31:0] owner_z;
        logic signed [31:0] target_x;
        logic signed [31:0] target_z;
        logic signed [15:0] facing;
        logic signed [23:0] rotation_speed;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [23:0] angular_accel;
    } out_item_t;

    typedef struct packed {
        logic [13:0] target_radius;
        logic [13:0] slow_radius;
        logic [15:0] time_to_target;
        logic [22:0] max_rotation_speed;
        logic [22:0] max_rotation_accel;
    } cfg_t;

    // Classified item handed from the front to the back.
    typedef struct packed {
        logic [1:0]         status;
        logic               neg;
        logic [13:0]        mag;
        logic signed [23:0] rotation_speed;
    } cls_item_t;

    // Arctangent of 2^-idx in Q28, rounded to nearest.
    function automatic logic signed [ANG_W-1:0] atan_q28(input int idx);
        logic signed [ANG_W-1:0] r;
        case (idx)
            0:  r = 32'sd210828714;
            1:  r = 32'sd124459457;
            2:  r = 32'sd65760959;
            3:  r = 32'sd33381290;
            4:  r = 32'sd16755422;
            5:  r = 32'sd8385879;
            6:  r = 32'sd4193963;
            7:  r = 32'sd2097109;
            8:  r = 32'sd1048571;
            9:  r = 32'sd524287;
            10: r = 32'sd262144;
            11: r = 32'sd131072;
            12: r = 32'sd65536;
            13: r = 32'sd32768;
            14: r = 32'sd16384;
            15: r = 32'sd8192;
            16: r = 32'sd4096;
            17: r = 32'sd2048;
            18: r = 32'sd1024;
            19: r = 32'sd512;
            20: r = 32'sd256;
            21: r = 32'sd128;
            22: r = 32'sd64;
            23: r = 32'sd32;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/core/ftrc_front.sv @@
`timescale 1ns / 1ps

module ftrc_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ftrc_pkg::cfg_t       cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ftrc_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ftrc_pkg::cls_item_t  out_data
);

    localparam int N = ftrc_pkg::CORDIC_STAGES;
    localparam int W = ftrc_pkg::CORDIC_W;

    logic adv;

    // Input capture stage.
    ftrc_pkg::in_item_t in_reg;
    logic               v_in_reg;

    // Difference stage.
    logic signed [32:0] dx_reg, dz_reg;
    logic signed [15:0] fac_d_reg;
    logic signed [23:0] spd_d_reg;
    logic               v_d_reg;

    // CORDIC stages; index 0 holds the prerotated vector.
    logic signed [W-1:0]                 cx_reg   [0:N];
    logic signed [W-1:0]                 cy_reg   [0:N];
    logic signed [ftrc_pkg::ANG_W-1:0]   cz_reg   [0:N];
    logic signed [W-1:0]                 cx_next  [0:N];
    logic signed [W-1:0]                 cy_next  [0:N];
    logic signed [ftrc_pkg::ANG_W-1:0]   cz_next  [0:N];
    logic signed [15:0]                  fac_c_reg [0:N];
    logic signed [23:0]                  spd_c_reg [0:N];
    logic                                coin_c_reg [0:N];
    logic                                v_c_reg   [0:N];

    // Wrap stage.
    logic signed [15:0] err_reg, err_next;
    logic signed [23:0] spd_w_reg;
    logic               coin_w_reg;
    logic               v_w_reg;

    // Classification stage.
    ftrc_pkg::cls_item_t cls_reg, cls_next;
    logic                v_cls_reg;

    assign adv       = !v_cls_reg || out_ready;
    assign in_ready  = adv;
    assign out_valid = v_cls_reg;
    assign out_data  = cls_reg;

    // Prerotation into the right half plane, then the vectoring iterations.
    always_comb begin
        logic signed [W-1:0] x0;
        logic signed [W-1:0] y0;
        x0 = $signed({{3{dz_reg[32]}}, dz_reg, 24'd0});
        y0 = -$signed({{3{dx_reg[32]}}, dx_reg, 24'd0});
        if (x0[W-1]) begin
            if (!y0[W-1]) begin
                cx_next[0] = y0;
                cy_next[0] = -x0;
                cz_next[0] = ftrc_pkg::HALF_PI_Q28;
            end else begin
                cx_next[0] = -y0;
                cy_next[0] = x0;
                cz_next[0] = -ftrc_pkg::HALF_PI_Q28;
            end
        end else begin
            cx_next[0] = x0;
            cy_next[0] = y0;
            cz_next[0] = '0;
        end
        for (int i = 0; i < N; i++) begin
            if (!cy_reg[i][W-1] && (cy_reg[i] != '0)) begin
                cx_next[i+1] = cx_reg[i] + (cy_reg[i] >>> i);
                cy_next[i+1] = cy_reg[i] - (cx_reg[i] >>> i);
                cz_next[i+1] = cz_reg[i] + ftrc_pkg::atan_q28(i);
            end else begin
                cx_next[i+1] = cx_reg[i] - (cy_reg[i] >>> i);
                cy_next[i+1] = cy_reg[i] + (cx_reg[i] >>> i);
                cz_next[i+1] = cz_reg[i] - ftrc_pkg::atan_q28(i);
            end
        end
    end

    // Round the bearing to Q3.12 and wrap bearing minus facing into [-pi, pi).
    always_comb begin
        logic signed [ftrc_pkg::ANG_W-1:0] zr;
        logic signed [15:0]                bear;
        logic signed [17:0]                v;
        logic [17:0]                       u;
        logic [17:0]                       m;
        logic signed [17:0]                e;
        zr   = cz_reg[N] + ftrc_pkg::ROUND_Q16;
        bear = zr[31:16];
        v    = 18'(bear) - 18'(fac_c_reg[N]) + ftrc_pkg::ANG_PI;
        u    = 18'(v + 18'sd51472);
        if (u >= 18'(4 * ftrc_pkg::ANG_2PI)) begin
            m = u - 18'(4 * ftrc_pkg::ANG_2PI);
        end else if (u >= 18'(3 * ftrc_pkg::ANG_2PI)) begin
            m = u - 18'(3 * ftrc_pkg::ANG_2PI);
        end else if (u >= 18'(2 * ftrc_pkg::ANG_2PI)) begin
            m = u - 18'(2 * ftrc_pkg::ANG_2PI);
        end else if (u >= ftrc_pkg::ANG_2PI) begin
            m = u - ftrc_pkg::ANG_2PI;
        end else begin
            m = u;
        end
        e        = $signed(m) - ftrc_pkg::ANG_PI;
        err_next = e[15:0];
    end

    // Status from coincidence and the target radius.
    always_comb begin
        logic [15:0] a;
        a = err_reg[15] ? 16'(-err_reg) : 16'(err_reg);
        cls_next.neg            = err_reg[15];
        cls_next.mag            = a[13:0];
        cls_next.rotation_speed = spd_w_reg;
        if (coin_w_reg) begin
            cls_next.status = ftrc_pkg::STATUS_COINCIDE;
        end else if ((a[13:0] == '0) || (a[13:0] < cfg.target_radius)) begin
            cls_next.status = ftrc_pkg::STATUS_IN_RADIUS;
        end else begin
            cls_next.status = ftrc_pkg::STATUS_STEER;
        end
    end

    // Valid bits of every stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_in_reg  <= 1'b0;
            v_d_reg   <= 1'b0;
            v_w_reg   <= 1'b0;
            v_cls_reg <= 1'b0;
            for (int i = 0; i <= N; i++) begin
                v_c_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            v_in_reg   <= in_valid;
            v_d_reg    <= v_in_reg;
            v_c_reg[0] <= v_d_reg;
            for (int i = 0; i < N; i++) begin
                v_c_reg[i+1] <= v_c_reg[i];
            end
            v_w_reg   <= v_c_reg[N];
            v_cls_reg <= v_w_reg;
        end
    end

    // Payload of every stage.
    always_ff @(posedge aclk) begin
        if (adv) begin
            in_reg    <= in_data;
            dx_reg    <= 33'(in_reg.target_x) - 33'(in_reg.owner_x);
            dz_reg    <= 33'(in_reg.target_z) - 33'(in_reg.owner_z);
            fac_d_reg <= in_reg.facing;
            spd_d_reg <= in_reg.rotation_speed;
            for (int i = 0; i <= N; i++) begin
                cx_reg[i] <= cx_next[i];
                cy_reg[i] <= cy_next[i];
                cz_reg[i] <= cz_next[i];
            end
            fac_c_reg[0]  <= fac_d_reg;
            spd_c_reg[0]  <= spd_d_reg;
            coin_c_reg[0] <= (dx_reg == '0) && (dz_reg == '0);
            for (int i = 0; i < N; i++) begin
                fac_c_reg[i+1]  <= fac_c_reg[i];
                spd_c_reg[i+1]  <= spd_c_reg[i];
                coin_c_reg[i+1] <= coin_c_reg[i];
            end
            err_reg    <= err_next;
            spd_w_reg  <= spd_c_reg[N];
            coin_w_reg <= coin_c_reg[N];
            cls_reg    <= cls_next;
        end
    end

endmodule

@@ rtl/core/ftrc_queue.sv @@
`timescale 1ns / 1ps

module ftrc_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ftrc_pkg::cls_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ftrc_pkg::cls_item_t  out_data
);

    ftrc_pkg::cls_item_t               mem [0:ftrc_pkg::QUEUE_DEPTH-1];
    logic [ftrc_pkg::QUEUE_AW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [ftrc_pkg::QUEUE_AW:0]       count_reg, count_next;
    logic                              push, pop;

    assign in_ready  = (count_reg != (ftrc_pkg::QUEUE_AW+1)'(ftrc_pkg::QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Occupancy after this cycle's transfers.
    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

endmodule

@@ rtl/core/ftrc_div.sv @@
`timescale 1ns / 1ps

module ftrc_div (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic [ftrc_pkg::DIV_DW-1:0]        hi,
    input  logic [ftrc_pkg::DIV_STEPS-1:0]     lo,
    input  logic [ftrc_pkg::DIV_DW-1:0]        divisor,
    input  logic [ftrc_pkg::DIV_TAG_W-1:0]     in_tag,
    output logic                               out_valid,
    output logic [ftrc_pkg::DIV_STEPS-1:0]     quot,
    output logic [ftrc_pkg::DIV_TAG_W-1:0]     out_tag
);

    localparam int S  = ftrc_pkg::DIV_STEPS;
    localparam int DW = ftrc_pkg::DIV_DW;

    // Each stage holds the partial remainder and a word that shifts the
    // dividend bits out at the top and the quotient bits in at the bottom.
    logic [DW-1:0]                    rem_reg  [0:S];
    logic [S-1:0]                     ql_reg   [0:S];
    logic [ftrc_pkg::DIV_TAG_W-1:0]   tag_reg  [0:S];
    logic                             v_reg    [0:S];
    logic [DW-1:0]                    rem_next [1:S];
    logic [S-1:0]                     ql_next  [1:S];

    // One restoring step per stage.
    always_comb begin
        logic [DW:0] sh;
        logic        ge;
        for (int k = 0; k < S; k++) begin
            sh = {rem_reg[k], ql_reg[k][S-1]};
            ge = (sh >= {1'b0, divisor});
            if (ge) begin
                rem_next[k+1] = DW'(sh - {1'b0, divisor});
            end else begin
                rem_next[k+1] = sh[DW-1:0];
            end
            ql_next[k+1] = {ql_reg[k][S-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= S; k++) begin
                v_reg[k] <= 1'b0;
            end
        end else if (en) begin
            v_reg[0] <= in_valid;
            for (int k = 0; k < S; k++) begin
                v_reg[k+1] <= v_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= hi;
            ql_reg[0]  <= lo;
            tag_reg[0] <= in_tag;
            for (int k = 0; k < S; k++) begin
                rem_reg[k+1] <= rem_next[k+1];
                ql_reg[k+1]  <= ql_next[k+1];
                tag_reg[k+1] <= tag_reg[k];
            end
        end
    end

    assign out_valid = v_reg[S];
    assign quot      = ql_reg[S];
    assign out_tag   = tag_reg[S];

endmodule

@@ rtl/core/ftrc_back.sv @@
`timescale 1ns / 1ps

module ftrc_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ftrc_pkg::cfg_t       cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ftrc_pkg::cls_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ftrc_pkg::out_item_t  out_data
);

    logic adv;

    // Stage taking the queue head.
    ftrc_pkg::cls_item_t b0_reg;
    logic                v_b0_reg;

    // Product stage.
    logic [36:0]        prod_reg;
    logic [1:0]         st1_reg;
    logic               neg1_reg, over1_reg;
    logic signed [23:0] spd1_reg;
    logic               v_b1_reg;

    // First divider: wanted speed.
    logic                             d1_valid;
    logic [ftrc_pkg::DIV_STEPS-1:0]   d1_quot;
    logic [ftrc_pkg::DIV_TAG_W-1:0]   d1_tag;

    // Speed difference stage.
    logic [23:0] absd_reg, absd_next;
    logic [1:0]  st2_reg;
    logic        sign2_reg, sign2_next;
    logic        ovf2_reg, ovf2_next;
    logic        zero2_reg, zero2_next;
    logic        v_b2_reg;

    // Second divider: acceleration.
    logic                             d2_valid;
    logic [ftrc_pkg::DIV_STEPS-1:0]   d2_quot;
    logic [ftrc_pkg::DIV_TAG_W-1:0]   d2_tag;

    // Output stage.
    ftrc_pkg::out_item_t out_reg, out_next;
    logic                v_out_reg;

    assign adv       = !v_out_reg || out_ready;
    assign in_ready  = adv;
    assign out_valid = v_out_reg;
    assign out_data  = out_reg;

    ftrc_div u_div_speed (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (v_b1_reg),
        .hi        ({2'b00, prod_reg[36:23]}),
        .lo        (prod_reg[22:0]),
        .divisor   ({2'b00, cfg.slow_radius}),
        .in_tag    ({st1_reg, neg1_reg, over1_reg, spd1_reg}),
        .out_valid (d1_valid),
        .quot      (d1_quot),
        .out_tag   (d1_tag)
    );

    // Signed wanted speed minus current speed, kept as sign and magnitude.
    always_comb begin
        logic [22:0]        w;
        logic signed [24:0] sw;
        logic signed [24:0] diff;
        logic [24:0]        a;
        w    = d1_tag[24] ? cfg.max_rotation_speed : d1_quot;
        sw   = d1_tag[25] ? -$signed({2'b00, w}) : $signed({2'b00, w});
        diff = sw - 25'(signed'(d1_tag[23:0]));
        a    = diff[24] ? 25'(-diff) : 25'(diff);
        absd_next  = a[23:0];
        sign2_next = diff[24];
        zero2_next = (diff == '0);
        // Quotient of at least 2^23 always clamps.
        ovf2_next  = ({3'b000, a[23:11]} >= cfg.time_to_target);
    end

    ftrc_div u_div_accel (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (v_b2_reg),
        .hi        ({3'b000, absd_reg[23:11]}),
        .lo        ({absd_reg[10:0], 12'd0}),
        .divisor   (cfg.time_to_target),
        .in_tag    ({23'd0, st2_reg, sign2_reg, ovf2_reg, zero2_reg}),
        .out_valid (d2_valid),
        .quot      (d2_quot),
        .out_tag   (d2_tag)
    );

    // Clamp, apply the sign and blank results without steering.
    always_comb begin
        logic [22:0] mq;
        if (d2_tag[1] || (d2_quot > cfg.max_rotation_accel)) begin
            mq = cfg.max_rotation_accel;
        end else begin
            mq = d2_quot;
        end
        out_next.status = d2_tag[4:3];
        if (d2_tag[0] || (d2_tag[4:3] != ftrc_pkg::STATUS_STEER)) begin
            out_next.angular_accel = '0;
        end else if (d2_tag[2]) begin
            out_next.angular_accel = -$signed({1'b0, mq});
        end else begin
            out_next.angular_accel = $signed({1'b0, mq});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_b0_reg  <= 1'b0;
            v_b1_reg  <= 1'b0;
            v_b2_reg  <= 1'b0;
            v_out_reg <= 1'b0;
        end else if (adv) begin
            v_b0_reg  <= in_valid;
            v_b1_reg  <= v_b0_reg;
            v_b2_reg  <= d1_valid;
            v_out_reg <= d2_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b0_reg    <= in_data;
            prod_reg  <= 37'(cfg.max_rotation_speed) * 37'(b0_reg.mag);
            st1_reg   <= b0_reg.status;
            neg1_reg  <= b0_reg.neg;
            over1_reg <= (b0_reg.mag > cfg.slow_radius);
            spd1_reg  <= b0_reg.rotation_speed;
            absd_reg  <= absd_next;
            st2_reg   <= d1_tag[27:26];
            sign2_reg <= sign2_next;
            ovf2_reg  <= ovf2_next;
            zero2_reg <= zero2_next;
            out_reg   <= out_next;
        end
    end

endmodule

@@ rtl/core/face_target_rotation_controller_unit.sv @@
// Throughput: one item per cycle while m_ready is high, set by the fully
// pipelined CORDIC and the two restoring dividers, each one bit per stage.
// When m_ready is low the back stalls, and the front once the queue is full.
// Reset: synchronous, active low; clears all valid bits and the queue and
// loads the configuration registers with their reset values.
`timescale 1ns / 1ps

module face_target_rotation_controller_unit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  ftrc_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ftrc_pkg::out_item_t  m_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    ftrc_pkg::cfg_t      cfg_reg;
    logic                cfg_wr;
    logic                q_in_valid, q_in_ready;
    ftrc_pkg::cls_item_t q_in_data;
    logic                q_out_valid, q_out_ready;
    ftrc_pkg::cls_item_t q_out_data;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Configuration register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_radius      <= ftrc_pkg::TARGET_RADIUS_RST;
            cfg_reg.slow_radius        <= ftrc_pkg::SLOW_RADIUS_RST;
            cfg_reg.time_to_target     <= ftrc_pkg::TIME_TO_TGT_RST;
            cfg_reg.max_rotation_speed <= ftrc_pkg::MAX_SPEED_RST;
            cfg_reg.max_rotation_accel <= ftrc_pkg::MAX_ACCEL_RST;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                ftrc_pkg::CFG_TARGET_RADIUS: cfg_reg.target_radius      <= pwdata[13:0];
                ftrc_pkg::CFG_SLOW_RADIUS:   cfg_reg.slow_radius        <= pwdata[13:0];
                ftrc_pkg::CFG_TIME_TO_TGT:   cfg_reg.time_to_target     <= pwdata[15:0];
                ftrc_pkg::CFG_MAX_SPEED:     cfg_reg.max_rotation_speed <= pwdata[22:0];
                ftrc_pkg::CFG_MAX_ACCEL:     cfg_reg.max_rotation_accel <= pwdata[22:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (paddr[4:2])
            ftrc_pkg::CFG_TARGET_RADIUS: prdata = {18'd0, cfg_reg.target_radius};
            ftrc_pkg::CFG_SLOW_RADIUS:   prdata = {18'd0, cfg_reg.slow_radius};
            ftrc_pkg::CFG_TIME_TO_TGT:   prdata = {16'd0, cfg_reg.time_to_target};
            ftrc_pkg::CFG_MAX_SPEED:     prdata = {9'd0, cfg_reg.max_rotation_speed};
            ftrc_pkg::CFG_MAX_ACCEL:     prdata = {9'd0, cfg_reg.max_rotation_accel};
            default:                     prdata = '0;
        endcase
    end

    ftrc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (q_in_valid),
        .out_ready (q_in_ready),
        .out_data  (q_in_data)
    );

    ftrc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_in_valid),
        .in_ready  (q_in_ready),
        .in_data   (q_in_data),
        .out_valid (q_out_valid),
        .out_ready (q_out_ready),
        .out_data  (q_out_data)
    );

    ftrc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (q_out_valid),
        .in_ready  (q_out_ready),
        .in_data   (q_out_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

    // A result without steering carries no acceleration.
    a_no_steer_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status != ftrc_pkg::STATUS_STEER))
        |-> (m_data.angular_accel == '0))
        else $error("nonzero acceleration on a result without steering");

    // The commanded acceleration stays within the configured limit.
    a_accel_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |->
        (($signed({m_data.angular_accel[23], m_data.angular_accel})
            <= $signed({2'b00, cfg_reg.max_rotation_accel}))
        && ($signed({m_data.angular_accel[23], m_data.angular_accel})
            >= -$signed({2'b00, cfg_reg.max_rotation_accel}))))
        else $error("acceleration beyond the configured limit");

    // The front holds its classified item while the queue is full.
    a_front_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_in_valid && !q_in_ready) |=> (q_in_valid && $stable(q_in_data)))
        else $error("front dropped or changed an item while the queue was full");

endmodule
